// ----- design/rmp_pkg.sv -----
// Shared types and constants for the routing message parser.
`default_nettype none
package rmp_pkg;

  // Status codes of the end-of-message item
  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_SHORT   = 4'd1;
  localparam logic [3:0] ST_BADLEN  = 4'd2;
  localparam logic [3:0] ST_RESIDUE = 4'd3;
  localparam logic [3:0] ST_NOENT   = 4'd4;
  localparam logic [3:0] ST_TRUNC   = 4'd5;
  localparam logic [3:0] ST_RUNOFF  = 4'd6;
  localparam logic [3:0] ST_BADSEG  = 4'd7;
  localparam logic [3:0] ST_LONG    = 4'd8;

  // Format modes (the unused code behaves as level 2)
  localparam logic [1:0] MODE_P3 = 2'd0;
  localparam logic [1:0] MODE_L1 = 2'd1;
  localparam logic [1:0] MODE_RESET = MODE_L1;

  // Segment id limits and header layout
  localparam logic [16:0] L1_ID_LIMIT  = 17'd1024;
  localparam logic [16:0] L2_ID_LIMIT  = 17'd64;
  localparam int unsigned HEADER_BYTES = 4;

  // Ones' complement residue targets
  localparam logic [15:0] RES_P3 = 16'hffff;
  localparam logic [15:0] RES_P4 = 16'hfffe;

  // Result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // Segment parsing phase, one-hot
  typedef enum logic [2:0] {
    PH_COUNT   = 3'b001,
    PH_START   = 3'b010,
    PH_ENTRIES = 3'b100
  } seg_phase_t;

  // One result item as queued
  typedef struct packed {
    logic        is_status;
    logic [15:0] node_id;
    logic [15:0] entry_word;
    logic [3:0]  status;
    logic [7:0]  flags;
    logic [15:0] source;
  } rmp_item_t;

endpackage
`default_nettype wire

// ----- design/rmp_out_fifo.sv -----
// Result queue: takes up to two items a cycle, delivers one a cycle while pop_ready is high.
`default_nettype none
module rmp_out_fifo
  import rmp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [1:0] push_cnt,
  input  wire rmp_item_t push0,
  input  wire rmp_item_t push1,
  output logic           room_two,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output rmp_item_t      pop_item
);

  rmp_item_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [FIFO_AW:0]         cnt_r, cnt_nxt;
  logic                     pop;

  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem_r[rd_r];
  assign pop       = pop_valid && pop_ready;
  assign room_two  = (cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r + FIFO_AW'(push_cnt);
    rd_nxt  = rd_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + (FIFO_AW+1)'(push_cnt) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage; second item goes to the slot after the first
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_r + FIFO_AW'(1)] <= push1;
  end

endmodule
`default_nettype wire

// ----- design/routing_message_parser_top.sv -----
// Routing message parser: top level with byte parser, config and assertions.
//
// Takes one message byte per cycle. Each byte updates the parse state and
// writes its results (an entry item, the end-of-message status item, or
// both) into a four-item result queue, so bytes are taken back to back as
// long as the queue has room for two items; in_ready falls only while three
// or more items are waiting. Entries are emitted before the message is
// checked; the status item (run_last set) carries the top-priority error.
// The user must write format_mode only between messages; it is not enforced.
`default_nettype none
module routing_message_parser_top
  import rmp_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_is_status,
  output logic [15:0]      out_node_id,
  output logic [15:0]      out_entry_word,
  output logic [3:0]       out_status,
  output logic [2:0]       out_msg_type,
  output logic [2:0]       out_extended_type,
  output logic             out_control_flag,
  output logic             out_pf_flag,
  output logic [15:0]      out_source_node,
  output logic             out_run_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data
);

  localparam int unsigned POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);
  localparam logic [POS_W-1:0] POS_HDR = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_ONEWORD = POS_W'(HEADER_BYTES + 2);

  logic [1:0]       mode_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [15:0]      held_r, held_nxt;
  logic             held_v_r, held_v_nxt;
  logic [15:0]      sum_r, sum_nxt;
  seg_phase_t       phase_r, phase_nxt;
  logic [15:0]      left_r, left_nxt;
  logic [15:0]      id_r, id_nxt;
  logic             bad_r, bad_nxt;
  logic [3:0]       ferr_r, ferr_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [15:0]      src_r, src_nxt;

  logic             in_fire;
  logic             ent_v;
  logic [15:0]      ent_id, ent_word;
  logic [16:0]      sum17, res17, seg17;
  logic [15:0]      residue, left_dec;
  logic [3:0]       fin_st;
  logic             seg_ok;
  rmp_item_t        item_ent, item_st, push0, push1, head;
  logic [1:0]       push_cnt;
  logic             room_two;

  assign in_ready = room_two;
  assign in_fire  = in_valid && in_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Per-byte parse: header capture, word assembly, segment walk, status
  always_comb begin
    pos_nxt    = pos_r;
    low_nxt    = low_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    sum_nxt    = sum_r;
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    id_nxt     = id_r;
    bad_nxt    = bad_r;
    ferr_nxt   = ferr_r;
    flags_nxt  = flags_r;
    src_nxt    = src_r;
    ent_v      = 1'b0;
    ent_id     = '0;
    ent_word   = '0;
    sum17      = {1'b0, sum_r} + {1'b0, held_r};
    seg17      = {1'b0, left_r} + {1'b0, held_r};
    left_dec   = left_r - 16'd1;
    if (mode_r == MODE_L1) begin
      seg_ok = (left_r != '0) && (seg17 <= L1_ID_LIMIT);
    end else begin
      seg_ok = (left_r != '0) && (held_r != '0) && (seg17 <= L2_ID_LIMIT);
    end

    if (in_fire) begin
      if (ferr_r == ST_LONG || pos_r >= POS_MAX) begin
        ferr_nxt = ST_LONG;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r == POS_W'(0)) begin
          flags_nxt = in_data_byte;
        end else if (pos_r == POS_W'(1)) begin
          src_nxt[7:0] = in_data_byte;
        end else if (pos_r == POS_W'(2)) begin
          src_nxt[15:8] = in_data_byte;
        end else if (pos_r >= POS_HDR) begin
          if (!pos_r[0]) begin
            low_nxt = in_data_byte;
          end else begin
            // the previously held word becomes a body word
            if (held_v_r) begin
              sum_nxt = sum17[15:0] + 16'(sum17[16]);
              if (ferr_r == ST_OK) begin
                if (mode_r == MODE_P3) begin
                  ent_v    = 1'b1;
                  ent_id   = id_r;
                  ent_word = held_r;
                  id_nxt   = id_r + 16'd1;
                end else begin
                  unique case (phase_r)
                    PH_COUNT: begin
                      left_nxt  = held_r;
                      phase_nxt = PH_START;
                    end
                    PH_START: begin
                      id_nxt  = held_r;
                      bad_nxt = !seg_ok;
                      if (left_r == '0) begin
                        ferr_nxt  = ST_BADSEG;
                        phase_nxt = PH_COUNT;
                      end else begin
                        phase_nxt = PH_ENTRIES;
                      end
                    end
                    PH_ENTRIES: begin
                      ent_v    = 1'b1;
                      ent_id   = id_r;
                      ent_word = held_r;
                      id_nxt   = id_r + 16'd1;
                      left_nxt = left_dec;
                      if (left_dec == '0) begin
                        if (bad_r) ferr_nxt = ST_BADSEG;
                        phase_nxt = PH_COUNT;
                      end
                    end
                    default: phase_nxt = PH_COUNT;
                  endcase
                end
              end
            end
            held_nxt   = {in_data_byte, low_r};
            held_v_nxt = 1'b1;
          end
        end
      end
    end

    // Final status from the updated state
    res17   = {1'b0, sum_nxt} + {1'b0, ~held_nxt};
    residue = res17[15:0] + 16'(res17[16]);
    priority if (ferr_nxt == ST_LONG) begin
      fin_st = ST_LONG;
    end else if (pos_nxt < POS_HDR) begin
      fin_st = ST_SHORT;
    end else if (pos_nxt == POS_HDR || pos_nxt[0]) begin
      fin_st = ST_BADLEN;
    end else if (residue != ((mode_r == MODE_P3) ? RES_P3 : RES_P4)) begin
      fin_st = ST_RESIDUE;
    end else if (pos_nxt == POS_ONEWORD) begin
      fin_st = ST_NOENT;
    end else if (ferr_nxt != ST_OK) begin
      fin_st = ferr_nxt;
    end else if (mode_r != MODE_P3 && phase_nxt == PH_START) begin
      fin_st = ST_TRUNC;
    end else if (mode_r != MODE_P3 && phase_nxt == PH_ENTRIES) begin
      fin_st = ST_RUNOFF;
    end else begin
      fin_st = ST_OK;
    end

    // Result items carry the header as it stands after this byte
    item_ent = '{is_status: 1'b0, node_id: ent_id, entry_word: ent_word,
                 status: ST_OK, flags: flags_nxt, source: src_nxt};
    item_st  = '{is_status: 1'b1, node_id: 16'd0, entry_word: 16'd0,
                 status: fin_st, flags: flags_nxt, source: src_nxt};

    // Message end: everything but the mode goes back to reset
    if (in_fire && in_end_of_message) begin
      pos_nxt    = '0;
      low_nxt    = '0;
      held_nxt   = '0;
      held_v_nxt = 1'b0;
      sum_nxt    = '0;
      phase_nxt  = PH_COUNT;
      left_nxt   = '0;
      id_nxt     = 16'd1;
      bad_nxt    = 1'b0;
      ferr_nxt   = ST_OK;
      flags_nxt  = '0;
      src_nxt    = '0;
    end
  end

  // Queue write selection: entry first, then status
  always_comb begin
    push0    = ent_v ? item_ent : item_st;
    push1    = item_st;
    push_cnt = 2'(ent_v) + 2'(in_fire && in_end_of_message);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      low_r    <= '0;
      held_r   <= '0;
      held_v_r <= 1'b0;
      sum_r    <= '0;
      phase_r  <= PH_COUNT;
      left_r   <= '0;
      id_r     <= 16'd1;
      bad_r    <= 1'b0;
      ferr_r   <= ST_OK;
      flags_r  <= '0;
      src_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      low_r    <= low_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      sum_r    <= sum_nxt;
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      id_r     <= id_nxt;
      bad_r    <= bad_nxt;
      ferr_r   <= ferr_nxt;
      flags_r  <= flags_nxt;
      src_r    <= src_nxt;
    end
  end

  // Result queue
  rmp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .room_two  (room_two),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_item  (head)
  );

  // Output field unpacking
  assign out_is_status     = head.is_status;
  assign out_node_id       = head.node_id;
  assign out_entry_word    = head.entry_word;
  assign out_status        = head.status;
  assign out_msg_type      = head.flags[3:1];
  assign out_extended_type = head.flags[6:4];
  assign out_control_flag  = head.flags[0];
  assign out_pf_flag       = head.flags[7];
  assign out_source_node   = head.source;
  assign out_run_last      = head.is_status;

  // Checks
  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_message |=> pos_r == '0 && ferr_r == ST_OK)
    else $error("parse state not cleared after message end");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_status |-> out_status == ST_OK)
    else $error("entry item carries a status code");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("byte position beyond maximum message length");

endmodule
`default_nettype wire
